// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define OSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/osu_pkg.sv -----
// Package for the operand stack unit: operation codes, controller states
// and the command struct between controller and datapath. No dependencies.
`default_nettype none

package osu_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned VAL_W  = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_DUP  = 2'd1,
    FUNC_SWAP = 2'd2,
    FUNC_DROP = 2'd3
  } func_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic latch;   // capture operation, issue memory read
    logic commit;  // apply operation, load result register
  } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/osu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module osu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/osu_ctrl.sv -----
// Controller of the operand stack unit: accept/execute sequencing and
// the output valid flag. Depends on osu_pkg.
`default_nettype none

module osu_ctrl
  import osu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    in_ready_o   = 1'b0;
    cmd_o.latch  = 1'b0;
    cmd_o.commit = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // result register must be free or draining
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- hw/rtl/osu_dp.sv -----
// Datapath of the operand stack unit: cached top entry, entry count,
// stack memory below the top, and the result register.
// Depends on osu_pkg and osu_ram.
`default_nettype none

module osu_dp
  import osu_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 1024,
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cmd_t                    cmd_i,
  input  wire logic [FUNC_W-1:0]       func_i,
  input  wire logic signed [VAL_W-1:0] push_value_i,
  output logic                         overflow_o,
  output logic                         underflow_o,
  output logic [CW-1:0]                depth_o,
  output logic signed [VAL_W-1:0]      top_value_o
);

  func_e             func_q;
  logic [VAL_W-1:0]  value_q;
  logic [CW-1:0]     count_q, count_d;
  logic [VAL_W-1:0]  top_q, top_d;
  logic              ovf, unf;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [VAL_W-1:0]  wdata;
  logic [AW-1:0]     raddr;
  logic [VAL_W-1:0]  rdata;

  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic              empty, full, two_up;
  logic [VAL_W-1:0]  push_val;

  assign cnt_m1 = count_q - CW'(1);
  assign cnt_m2 = count_q - CW'(2);
  assign empty  = (count_q == '0);
  assign full   = (count_q == CW'(STACK_DEPTH));
  assign two_up = (count_q >= CW'(2));
  assign raddr  = two_up ? cnt_m2[AW-1:0] : '0;

  osu_ram #(
    .WIDTH(VAL_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.latch),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    count_d  = count_q;
    top_d    = top_q;
    ovf      = 1'b0;
    unf      = 1'b0;
    we       = 1'b0;
    waddr    = cnt_m1[AW-1:0];
    wdata    = top_q;
    push_val = (func_q == FUNC_PUSH) ? value_q : (empty ? '0 : top_q);
    case (func_q)
      FUNC_PUSH, FUNC_DUP: begin
        unf = (func_q == FUNC_DUP) && empty;
        if (full) begin
          ovf = 1'b1;
        end else begin
          we      = cmd_i.commit && !empty;
          top_d   = push_val;
          count_d = count_q + CW'(1);
        end
      end
      FUNC_SWAP: begin
        we = cmd_i.commit;
        if (two_up) begin
          waddr = cnt_m2[AW-1:0];
          top_d = rdata;
        end else begin
          unf     = 1'b1;
          waddr   = '0;
          wdata   = empty ? '0 : top_q;
          top_d   = '0;
          count_d = CW'(2);
        end
      end
      FUNC_DROP: begin
        if (empty) begin
          unf   = 1'b1;
          top_d = '0;
        end else begin
          count_d = cnt_m1;
          top_d   = two_up ? rdata : '0;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q  <= func_e'(func_i);
      value_q <= push_value_i;
    end
    if (cmd_i.commit) begin
      top_q       <= top_d;
      overflow_o  <= ovf;
      underflow_o <= unf;
      depth_o     <= count_d;
      top_value_o <= top_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/operand_stack_unit.sv -----
// Top level of the operand stack unit: controller plus datapath.
// Depends on osu_pkg, osu_ctrl, osu_dp (and osu_ram through osu_dp).
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   input    | in_valid_i/in_ready_o | func_i, push_value_i
//   output   | out_valid_o/out_ready_i | overflow_o, underflow_o, depth_o,
//            |                       | top_value_o
//
// Each operation has a transfer cycle, which issues the memory read of the
// second entry, and an execute cycle that uses the registered read data and
// writes the old top back if it stays. One operation is in flight at a time.
// Reset clears the controller and the entry count; the memory needs no clearing.
// A stalled result holds the execute cycle until the output transfer frees
// the result register; no new input transfer is accepted while it waits.
`default_nettype none

module operand_stack_unit
  import osu_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 1024,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [FUNC_W-1:0]       func_i,
  input  wire logic signed [VAL_W-1:0] push_value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         overflow_o,
  output logic                         underflow_o,
  output logic [CW-1:0]                depth_o,
  output logic signed [VAL_W-1:0]      top_value_o
);

  cmd_t cmd;

  osu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  osu_dp #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .func_i      (func_i),
    .push_value_i(push_value_i),
    .overflow_o  (overflow_o),
    .underflow_o (underflow_o),
    .depth_o     (depth_o),
    .top_value_o (top_value_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/osu_checker.sv -----
// Port-level checker for operand_stack_unit, bound to the top level.
// Depends on osu_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module osu_checker
  import osu_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 1024,
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o,
  input wire logic [FUNC_W-1:0]       func_i,
  input wire logic signed [VAL_W-1:0] push_value_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic                    overflow_o,
  input wire logic                    underflow_o,
  input wire logic [CW-1:0]           depth_o,
  input wire logic signed [VAL_W-1:0] top_value_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o && (func_i == func_i)
                   && (push_value_i == push_value_i);

  `OSU_ASSERT_NXT(a_one_in_flight, in_xfer, !in_ready_o, "input taken while busy")
  `OSU_ASSERT_NOW(a_depth_range, out_valid_o, depth_o <= CW'(STACK_DEPTH), "depth too large")
  `OSU_ASSERT_NOW(a_empty_top, out_valid_o && depth_o == '0, top_value_o == '0, "nonzero top")
  `OSU_ASSERT_NOW(a_ovf_full, out_valid_o && overflow_o, depth_o == CW'(STACK_DEPTH), "ovf not full")
  `OSU_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(top_value_o) && $stable(depth_o) && $stable(underflow_o),
                  "result changed while stalled")

endmodule

bind operand_stack_unit osu_checker #(.STACK_DEPTH(STACK_DEPTH)) u_osu_checker (.*);

`default_nettype wire

// ----- test/tb_operand_stack_unit.sv -----
// Testbench for operand_stack_unit: corner cases, then random push/dup/swap/drop
// traffic that climbs toward full, checked against an in-bench stack predictor.
// Depends on osu_pkg and the operand_stack_unit RTL.
`default_nettype none

module tb_operand_stack_unit;
  import osu_pkg::*;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RAND_PER_PHASE = 218;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_REPORTS = 10;

  localparam int PH_STEADY = 0;
  localparam int PH_SRC_IDLE = 1;
  localparam int PH_SINK_STALL = 2;
  localparam int PH_BOTH = 3;

  localparam int MODE_CLIMB = 0;
  localparam int MODE_TOP = 1;
  localparam int MODE_FALL = 2;
  localparam int MODE_BOTTOM = 3;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_ONES = 32'hffff_ffff;

  typedef struct {
    func_e            op;
    logic [VAL_W-1:0] val;
    int               phase;
  } stack_op_t;

  typedef struct {
    logic               overflow;
    logic               underflow;
    logic [DEPTH_W-1:0] depth;
    logic [VAL_W-1:0]   top;
  } stack_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_ready_o;
  func_e                   func = FUNC_PUSH;
  logic signed [VAL_W-1:0] push_value = '0;
  logic                    out_valid_o;
  logic                    out_ready = 1'b0;
  logic                    overflow_o;
  logic                    underflow_o;
  logic [DEPTH_W-1:0]      depth_o;
  logic signed [VAL_W-1:0] top_value_o;

  operand_stack_unit #(
    .STACK_DEPTH (STACK_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .func_i       (func),
    .push_value_i (push_value),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .overflow_o   (overflow_o),
    .underflow_o  (underflow_o),
    .depth_o      (depth_o),
    .top_value_o  (top_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stack_op_t     op_queue[$];
  stack_result_t expected_results[$];
  stack_op_t     next_op;
  int            cur_phase = PH_STEADY;
  int unsigned   err_count = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   plan_depth = 0;

  // Stack predictor
  logic [VAL_W-1:0] stk_mem[STACK_DEPTH];
  int unsigned      stk_cnt = 0;
  logic             ovf_flag;
  logic             unf_flag;

  function automatic void stk_push(logic [VAL_W-1:0] v);
    if (stk_cnt >= STACK_DEPTH) begin
      ovf_flag = 1'b1;
    end else begin
      stk_mem[stk_cnt] = v;
      stk_cnt++;
    end
  endfunction

  function automatic logic [VAL_W-1:0] stk_pop();
    if (stk_cnt == 0) begin
      unf_flag = 1'b1;
      return '0;
    end
    stk_cnt--;
    return stk_mem[stk_cnt];
  endfunction

  function automatic stack_result_t apply_op(func_e op, logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] a, b;
    stack_result_t    r;
    ovf_flag = 1'b0;
    unf_flag = 1'b0;
    case (op)
      FUNC_PUSH: stk_push(v);
      FUNC_DUP: begin
        if (stk_cnt == 0) begin
          unf_flag = 1'b1;
          a = '0;
        end else begin
          a = stk_mem[stk_cnt-1];
        end
        stk_push(a);
      end
      FUNC_SWAP: begin
        a = stk_pop();
        b = stk_pop();
        stk_push(a);
        stk_push(b);
      end
      default: a = stk_pop();
    endcase
    r.overflow = ovf_flag;
    r.underflow = unf_flag;
    r.depth = stk_cnt[DEPTH_W-1:0];
    r.top = (stk_cnt == 0) ? '0 : stk_mem[stk_cnt-1];
    return r;
  endfunction

  function automatic bit send_idle(int phase);
    return (phase == PH_SRC_IDLE && $urandom_range(99) < 69) ||
           (phase == PH_BOTH && $urandom_range(99) < 7);
  endfunction

  function automatic bit sink_stall(int phase);
    return (phase == PH_SINK_STALL && $urandom_range(99) < 69) ||
           (phase == PH_BOTH && $urandom_range(99) < 7);
  endfunction

  function automatic func_e pick_func(int mode);
    int unsigned r;
    r = $urandom_range(99);
    if (mode == MODE_TOP || mode == MODE_BOTTOM || $urandom_range(99) < 8)
      return func_e'($urandom_range(3));
    if (mode == MODE_CLIMB)
      return (r < 88) ? FUNC_PUSH : (r < 94) ? FUNC_DUP : (r < 97) ? FUNC_SWAP : FUNC_DROP;
    return (r < 88) ? FUNC_DROP : (r < 93) ? FUNC_SWAP : (r < 97) ? FUNC_DUP : FUNC_PUSH;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(19))
      0: return '0;
      1: return VAL_ONES;
      2: return VAL_MIN;
      3: return VAL_MAX;
      default: return $urandom;
    endcase
  endfunction

  // plan_depth tracks the depth only to steer the random walk
  task automatic add_op(func_e op, logic [VAL_W-1:0] v, int phase);
    stack_op_t item;
    item.op = op;
    item.val = v;
    item.phase = phase;
    op_queue.push_back(item);
    case (op)
      FUNC_PUSH, FUNC_DUP: if (plan_depth < STACK_DEPTH) plan_depth++;
      FUNC_SWAP: if (plan_depth < 2) plan_depth = 2;
      default: if (plan_depth > 0) plan_depth--;
    endcase
  endtask

  task automatic report(string what, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
  endtask

  // Driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_results.push_back(apply_op(func, push_value));
      end
      if (!in_valid || in_ready_o) begin
        if (op_queue.size() > 0 && !send_idle(op_queue[0].phase)) begin
          next_op = op_queue.pop_front();
          cur_phase <= next_op.phase;
          in_valid <= 1'b1;
          func <= next_op.op;
          push_value <= next_op.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    stack_result_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_results.size() == 0) begin
          report("result with no transfer pending, top", 'x, top_value_o);
        end else begin
          e = expected_results.pop_front();
          if (overflow_o !== e.overflow) report("overflow", e.overflow, overflow_o);
          if (underflow_o !== e.underflow) report("underflow", e.underflow, underflow_o);
          if (depth_o !== e.depth) report("depth", e.depth, depth_o);
          if (top_value_o !== e.top) report("top_value", e.top, top_value_o);
        end
      end
      out_ready <= !sink_stall(cur_phase);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int mode;
    int hold;
    mode = MODE_CLIMB;
    hold = 0;

    // empty-stack corner cases, swap on one entry, extremes of the value
    add_op(FUNC_DROP, $urandom, PH_STEADY);
    add_op(FUNC_SWAP, $urandom, PH_STEADY);
    add_op(FUNC_DROP, $urandom, PH_STEADY);
    add_op(FUNC_DROP, $urandom, PH_STEADY);
    add_op(FUNC_DROP, $urandom, PH_STEADY);
    add_op(FUNC_DUP, $urandom, PH_STEADY);
    add_op(FUNC_DROP, $urandom, PH_STEADY);
    add_op(FUNC_PUSH, VAL_MAX, PH_STEADY);
    add_op(FUNC_SWAP, $urandom, PH_STEADY);
    add_op(FUNC_PUSH, VAL_MIN, PH_STEADY);
    add_op(FUNC_PUSH, VAL_ONES, PH_STEADY);
    add_op(FUNC_PUSH, '0, PH_STEADY);
    add_op(FUNC_DUP, $urandom, PH_STEADY);
    add_op(FUNC_SWAP, $urandom, PH_STEADY);
    add_op(FUNC_PUSH, 32'h5555_5555, PH_STEADY);
    add_op(FUNC_PUSH, 32'haaaa_aaaa, PH_STEADY);
    add_op(FUNC_SWAP, $urandom, PH_STEADY);
    add_op(FUNC_DUP, $urandom, PH_STEADY);
    for (int i = 0; i < 10; i++) add_op(FUNC_DROP, $urandom, PH_STEADY);

    // random walk: climb to full, linger, drain to empty, repeat; too short to fill
    for (int ph = PH_STEADY; ph <= PH_BOTH; ph++) begin
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        case (mode)
          MODE_CLIMB: if (plan_depth == STACK_DEPTH) begin
            mode = MODE_TOP;
            hold = $urandom_range(80, 40);
          end
          MODE_TOP: if (--hold <= 0) mode = MODE_FALL;
          MODE_FALL: if (plan_depth == 0) begin
            mode = MODE_BOTTOM;
            hold = $urandom_range(40, 20);
          end
          default: if (--hold <= 0) mode = MODE_CLIMB;
        endcase
        add_op(pick_func(mode), pick_value(), ph);
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (op_queue.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
